FILE: src/mfb_pkg.sv
// mfb_pkg: geometry constants, operation, status and mode codes and the
// sequencer state type of the monochrome frame blit engine
// no dependencies
package mfb_pkg;

  localparam int SCREEN_W    = 400;
  localparam int SCREEN_H    = 240;
  localparam int MAX_BLIT    = 24;
  localparam int ROW_BYTES   = (SCREEN_W + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_H;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int COLX_W = $clog2(SCREEN_W + 1);
  localparam int LINE_W = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
  localparam int ENDY_W = $clog2(SCREEN_H + 1);
  localparam int WID_W  = $clog2(MAX_BLIT + 1);
  localparam int PAT_W  = 24;
  localparam int SRC_W  = 32;

  localparam logic [2:0] OP_BLIT  = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAN = 3'd4;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_WIDTH   = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE = 2'd2;
  localparam logic [1:0] STAT_MODE    = 2'd3;

  localparam logic [1:0] MODE_OR     = 2'd0;
  localparam logic [1:0] MODE_XOR    = 2'd1;
  localparam logic [1:0] MODE_ANDNOT = 2'd2;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_RMW,
    S_READ,
    S_DONE
  } state_e;

endpackage

FILE: src/mono_framebuffer_blit_engine_core.sv
// mono_framebuffer_blit_engine_core: 1-bit frame store with raster ops,
// per-row dirty flags and a sequencer doing byte read-modify-writes
// depends on mfb_pkg
//
// Usage: one command transaction on the input channel (in_valid_i, in_stall_o)
// gives exactly one result transaction on the output channel (out_valid_o,
// out_stall_i). The frame lives in a single-port-write, registered-read RAM
// of ROW_BYTES * SCREEN_H bytes; dirty flags are flip-flops.
// Work from acceptance to the result appearing in the output register:
//   blit: a read-modify-write loop on the frame RAM over nbytes = 1..4
//         bytes touched, one byte per cycle, after the address setup and
//         followed by the trailing write-back and the output load
//   fill rect: an address setup and byte loop for each row of each strip
//   clear all: a sweep over all STORE_BYTES bytes, one RAM byte per cycle
//   read: a RAM read, then the output load; mark clean and errors: the output load
// The next command is accepted the cycle after the result is registered,
// while that result may still wait on a stalled receiver. A stalled output
// holds its payload; a second result then waits inside the block.
// After reset the block runs a clearing pass over all STORE_BYTES (12000) bytes
// that zeroes the frame; in_stall_o is high until it ends.
module mono_framebuffer_blit_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [9:0]  x_pos_i,
  input  logic [7:0]  y_pos_i,
  input  logic [9:0]  width_px_i,
  input  logic [7:0]  height_px_i,
  input  logic [23:0] pattern_i,
  input  logic [1:0]  blit_mode_i,
  input  logic        fill_solid_i,
  input  logic        fill_on_i,
  input  logic [5:0]  byte_col_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  read_data_o,
  output logic        row_dirty_o
);

  localparam int AW = mfb_pkg::ADDR_W;
  localparam int CW = mfb_pkg::COLX_W;
  localparam int LW = mfb_pkg::LINE_W;
  localparam int EW = mfb_pkg::ENDY_W;
  localparam int WW = mfb_pkg::WID_W;
  localparam int PW = mfb_pkg::PAT_W;
  localparam int SW = mfb_pkg::SRC_W;

  // frame memory
  logic [7:0] mem [mfb_pkg::STORE_BYTES];
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data, rdata_q;

  // control state
  mfb_pkg::state_e state_q, state_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [7:0]    fill_q, fill_d;
  logic          clear_op_q, clear_op_d;
  logic [mfb_pkg::SCREEN_H-1:0] dirty_q, dirty_d;
  logic          out_valid_q, out_valid_d;

  // job and byte loop registers
  logic          is_fill_q, is_fill_d;
  logic [CW-1:0] col_q, col_d, endx_q, endx_d;
  logic [LW-1:0] line_q, line_d, top_q, top_d;
  logic [EW-1:0] endy_q, endy_d;
  logic [WW-1:0] wid_q, wid_d;
  logic [PW-1:0] pat_q, pat_d;
  logic [1:0]    mode_q, mode_d;
  logic          solid_q, solid_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [SW-1:0] src_q, src_d;
  logic [2:0]    nbytes_q, nbytes_d, iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [1:0]    pidx_q, pidx_d;

  // pending result and output registers
  logic [1:0] res_status_q, res_status_d;
  logic [7:0] res_data_q, res_data_d;
  logic       res_dirty_q, res_dirty_d;
  logic [1:0] status_q, status_d;
  logic [7:0] rdata_out_q, rdata_out_d;
  logic       rdirty_out_q, rdirty_out_d;

  // setup arithmetic
  logic [CW-1:0] rem, m, base;
  logic [WW-1:0] wid;
  logic [2:0]    off;
  logic [PW-1:0] lowmask;
  logic [5:0]    span;
  logic [CW:0]   ncol;
  logic [10:0]   x_end;
  logic [8:0]    y_end;
  logic [7:0]    byte_sel;
  logic          accept;

  assign accept = in_valid_i && (state_q == mfb_pkg::S_IDLE);
  assign in_stall_o  = (state_q != mfb_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_out_q;
  assign row_dirty_o = rdirty_out_q;

  assign x_end = {1'b0, x_pos_i} + {1'b0, width_px_i};
  assign y_end = {1'b0, y_pos_i} + {1'b0, height_px_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    fill_d       = fill_q;
    clear_op_d   = clear_op_q;
    dirty_d      = dirty_q;
    out_valid_d  = out_valid_q && out_stall_i;
    is_fill_d    = is_fill_q;
    col_d        = col_q;
    endx_d       = endx_q;
    line_d       = line_q;
    top_d        = top_q;
    endy_d       = endy_q;
    wid_d        = wid_q;
    pat_d        = pat_q;
    mode_d       = mode_q;
    solid_d      = solid_q;
    addr_d       = addr_q;
    src_d        = src_q;
    nbytes_d     = nbytes_q;
    iss_d        = iss_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_dirty_d  = res_dirty_q;
    status_d     = status_q;
    rdata_out_d  = rdata_out_q;
    rdirty_out_d = rdirty_out_q;
    rd_en        = 1'b0;
    rd_addr      = addr_q + AW'(iss_q);
    wr_en        = 1'b0;
    wr_addr      = addr_q + AW'(pidx_q);
    wr_data      = rdata_q;
    byte_sel     = src_q[8*pidx_q +: 8];

    // strip width, mirrored start column and byte span of the current job
    rem     = endx_q - col_q;
    if (is_fill_q) begin
      wid = (rem > CW'(mfb_pkg::MAX_BLIT)) ? WW'(mfb_pkg::MAX_BLIT) : WW'(rem);
    end else begin
      wid = wid_q;
    end
    m       = CW'(mfb_pkg::SCREEN_W) - CW'(wid) - col_q;
    off     = m[2:0];
    base    = m >> 3;
    lowmask = (PW'(1) << wid) - PW'(1);
    span    = 6'(off) + 6'(wid) + 6'd7;
    ncol    = {1'b0, col_q} + (CW+1)'(mfb_pkg::MAX_BLIT);

    unique case (state_q)
      mfb_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        wr_data = fill_q;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == AW'(mfb_pkg::STORE_BYTES - 1)) begin
          sweep_d = '0;
          if (clear_op_q) begin
            res_status_d = mfb_pkg::STAT_DONE;
            state_d      = mfb_pkg::S_DONE;
          end else begin
            state_d = mfb_pkg::S_IDLE;
          end
        end
      end
      mfb_pkg::S_IDLE: begin
        if (accept) begin
          res_status_d = mfb_pkg::STAT_DONE;
          res_data_d   = '0;
          res_dirty_d  = 1'b0;
          state_d      = mfb_pkg::S_DONE;
          case (op_i)
            mfb_pkg::OP_BLIT: begin
              if (width_px_i == '0 || width_px_i > 10'(mfb_pkg::MAX_BLIT)) begin
                res_status_d = mfb_pkg::STAT_WIDTH;
              end else if ({1'b0, x_pos_i} >= 11'(mfb_pkg::SCREEN_W) ||
                           x_end > 11'(mfb_pkg::SCREEN_W) ||
                           {1'b0, y_pos_i} >= 9'(mfb_pkg::SCREEN_H)) begin
                res_status_d = mfb_pkg::STAT_OUTSIDE;
              end else if (blit_mode_i == mfb_pkg::MODE_BAD) begin
                res_status_d = mfb_pkg::STAT_MODE;
              end else begin
                is_fill_d = 1'b0;
                col_d     = CW'(x_pos_i);
                line_d    = LW'(y_pos_i);
                wid_d     = WW'(width_px_i);
                pat_d     = pattern_i;
                mode_d    = blit_mode_i;
                solid_d   = fill_solid_i;
                state_d   = mfb_pkg::S_SETUP;
              end
            end
            mfb_pkg::OP_FILL: begin
              if (x_end > 11'(mfb_pkg::SCREEN_W) || y_end > 9'(mfb_pkg::SCREEN_H)) begin
                res_status_d = mfb_pkg::STAT_OUTSIDE;
              end else if (width_px_i != '0 && height_px_i != '0) begin
                is_fill_d = 1'b1;
                col_d     = CW'(x_pos_i);
                endx_d    = CW'(x_end);
                line_d    = LW'(y_pos_i);
                top_d     = LW'(y_pos_i);
                endy_d    = EW'(y_end);
                pat_d     = '1;
                mode_d    = fill_on_i ? mfb_pkg::MODE_OR : mfb_pkg::MODE_ANDNOT;
                solid_d   = 1'b0;
                state_d   = mfb_pkg::S_SETUP;
              end
            end
            mfb_pkg::OP_CLEAR: begin
              dirty_d    = '0;
              fill_d     = 8'hff;
              clear_op_d = 1'b1;
              sweep_d    = '0;
              state_d    = mfb_pkg::S_CLEAR;
            end
            mfb_pkg::OP_READ: begin
              if ({1'b0, y_pos_i} >= 9'(mfb_pkg::SCREEN_H) ||
                  8'(byte_col_i) >= 8'(mfb_pkg::ROW_BYTES)) begin
                res_status_d = mfb_pkg::STAT_OUTSIDE;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = AW'(y_pos_i) * AW'(mfb_pkg::ROW_BYTES) + AW'(byte_col_i);
                res_dirty_d = dirty_q[LW'(y_pos_i)];
                state_d     = mfb_pkg::S_READ;
              end
            end
            mfb_pkg::OP_CLEAN: begin
              if ({1'b0, y_pos_i} >= 9'(mfb_pkg::SCREEN_H)) begin
                res_status_d = mfb_pkg::STAT_OUTSIDE;
              end else begin
                dirty_d[LW'(y_pos_i)] = 1'b0;
              end
            end
            default: res_status_d = mfb_pkg::STAT_MODE;
          endcase
        end
      end
      mfb_pkg::S_SETUP: begin
        addr_d   = AW'(line_q) * AW'(mfb_pkg::ROW_BYTES) + AW'(base);
        nbytes_d = span[5:3];
        if (solid_q && mode_q != mfb_pkg::MODE_XOR) begin
          src_d = (mode_q == mfb_pkg::MODE_ANDNOT) ? (SW'(lowmask) << off) : '0;
        end else begin
          src_d = SW'(pat_q & lowmask) << off;
        end
        iss_d   = '0;
        pend_d  = 1'b0;
        dirty_d[line_q] = 1'b1;
        state_d = mfb_pkg::S_RMW;
      end
      mfb_pkg::S_RMW: begin
        // write back the byte read last cycle while the next one, if any, is read
        if (pend_q) begin
          wr_en = 1'b1;
          case (mode_q)
            mfb_pkg::MODE_OR:  wr_data = rdata_q | byte_sel;
            mfb_pkg::MODE_XOR: wr_data = rdata_q ^ byte_sel;
            default:           wr_data = rdata_q & ~byte_sel;
          endcase
        end
        if (iss_q < nbytes_q) begin
          rd_en  = 1'b1;
          pend_d = 1'b1;
          pidx_d = iss_q[1:0];
          iss_d  = iss_q + 3'd1;
        end else begin
          pend_d = 1'b0;
          if (!is_fill_q) begin
            res_status_d = mfb_pkg::STAT_DONE;
            state_d      = mfb_pkg::S_DONE;
          end else if (EW'(line_q) + EW'(1) < endy_q) begin
            line_d  = line_q + LW'(1);
            state_d = mfb_pkg::S_SETUP;
          end else if (ncol >= {1'b0, endx_q}) begin
            res_status_d = mfb_pkg::STAT_DONE;
            state_d      = mfb_pkg::S_DONE;
          end else begin
            line_d  = top_q;
            col_d   = CW'(ncol);
            state_d = mfb_pkg::S_SETUP;
          end
        end
      end
      mfb_pkg::S_READ: begin
        res_status_d = mfb_pkg::STAT_DONE;
        res_data_d   = rdata_q;
        state_d      = mfb_pkg::S_DONE;
      end
      mfb_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          status_d     = res_status_q;
          rdata_out_d  = res_data_q;
          rdirty_out_d = res_dirty_q;
          clear_op_d   = 1'b0;
          state_d      = mfb_pkg::S_IDLE;
        end
      end
      default: state_d = mfb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfb_pkg::S_CLEAR;
      sweep_q     <= '0;
      fill_q      <= '0;
      clear_op_q  <= 1'b0;
      dirty_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      iss_q       <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      fill_q      <= fill_d;
      clear_op_q  <= clear_op_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      iss_q       <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_fill_q    <= is_fill_d;
    col_q        <= col_d;
    endx_q       <= endx_d;
    line_q       <= line_d;
    top_q        <= top_d;
    endy_q       <= endy_d;
    wid_q        <= wid_d;
    pat_q        <= pat_d;
    mode_q       <= mode_d;
    solid_q      <= solid_d;
    addr_q       <= addr_d;
    src_q        <= src_d;
    nbytes_q     <= nbytes_d;
    pidx_q       <= pidx_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_dirty_q  <= res_dirty_d;
    status_q     <= status_d;
    rdata_out_q  <= rdata_out_d;
    rdirty_out_q <= rdirty_out_d;
  end

endmodule

FILE: tb/mfb_frame_checker.sv
// mfb_frame_checker: watches the command and result channels of the frame blit engine,
// keeps its own frame bytes and row dirty flags and checks every result in order
// depends on mfb_pkg
module mfb_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  op_i,
  input  logic [9:0]  x_pos_i,
  input  logic [7:0]  y_pos_i,
  input  logic [9:0]  width_px_i,
  input  logic [7:0]  height_px_i,
  input  logic [23:0] pattern_i,
  input  logic [1:0]  blit_mode_i,
  input  logic        fill_solid_i,
  input  logic        fill_on_i,
  input  logic [5:0]  byte_col_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  read_data_i,
  input  logic        row_dirty_i,
  output int          mismatches_o,
  output int          awaiting_o,
  output int          compared_o
);

  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       dirty;
  } outcome_t;

  bit [7:0] frame [mfb_pkg::STORE_BYTES];
  bit       dirty_rows [mfb_pkg::SCREEN_H];
  outcome_t expected_outcomes [$];
  outcome_t head;
  int       mismatches = 0;
  int       awaiting = 0;
  int       compared = 0;

  assign mismatches_o = mismatches;
  assign awaiting_o   = awaiting;
  assign compared_o   = compared;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t: %s", $time, what);
  endtask

  // one row write of up to MAX_BLIT bits, checks in the order width, screen, mode
  function automatic logic [1:0] blit_span(input int x, input int w, input int y,
                                           input logic [23:0] pattern,
                                           input logic [1:0] mode, input logic solid);
    int          start;
    int          first;
    int          shift;
    int          nbytes;
    int          addr;
    logic [31:0] ones;
    logic [31:0] shifted;
    logic [7:0]  b;
    if (w < 1 || w > mfb_pkg::MAX_BLIT) return mfb_pkg::STAT_WIDTH;
    if (x >= mfb_pkg::SCREEN_W || x + w > mfb_pkg::SCREEN_W || y >= mfb_pkg::SCREEN_H)
      return mfb_pkg::STAT_OUTSIDE;
    if (mode == mfb_pkg::MODE_BAD) return mfb_pkg::STAT_MODE;
    // columns are mirrored: a span at x of width w starts at bit SCREEN_W - w - x of the row
    start  = mfb_pkg::SCREEN_W - w - x;
    first  = start >> 3;
    shift  = start & 7;
    nbytes = (shift + w + 7) / 8;
    ones   = (32'd1 << w) - 32'd1;
    if (solid && mode != mfb_pkg::MODE_XOR) begin
      shifted = (mode == mfb_pkg::MODE_ANDNOT) ? (ones << shift) : 32'd0;
    end else begin
      shifted = ({8'd0, pattern} & ones) << shift;
    end
    for (int i = 0; i < nbytes && i < 4; i++) begin
      if (first + i >= mfb_pkg::ROW_BYTES) break;
      addr = y * mfb_pkg::ROW_BYTES + first + i;
      b = shifted[8*i +: 8];
      case (mode)
        mfb_pkg::MODE_OR:  frame[addr] = frame[addr] | b;
        mfb_pkg::MODE_XOR: frame[addr] = frame[addr] ^ b;
        default:           frame[addr] = frame[addr] & ~b;
      endcase
    end
    dirty_rows[y] = 1'b1;
    return mfb_pkg::STAT_DONE;
  endfunction

  // strips of up to MAX_BLIT columns, each walked top to bottom
  function automatic logic [1:0] fill_rect(input int x, input int y, input int w,
                                           input int h, input logic on);
    int cols;
    if (x + w > mfb_pkg::SCREEN_W || y + h > mfb_pkg::SCREEN_H) return mfb_pkg::STAT_OUTSIDE;
    for (int col = x; col < x + w; col += mfb_pkg::MAX_BLIT) begin
      cols = (x + w - col > mfb_pkg::MAX_BLIT) ? mfb_pkg::MAX_BLIT : x + w - col;
      for (int row = y; row < y + h; row++) begin
        void'(blit_span(col, cols, row, 24'hFF_FFFF,
                        on ? mfb_pkg::MODE_OR : mfb_pkg::MODE_ANDNOT, 1'b0));
      end
    end
    return mfb_pkg::STAT_DONE;
  endfunction

  function automatic outcome_t apply_command(input logic [2:0] op, input logic [9:0] x,
                                             input logic [7:0] y, input logic [9:0] w,
                                             input logic [7:0] h, input logic [23:0] pattern,
                                             input logic [1:0] mode, input logic solid,
                                             input logic on, input logic [5:0] bcol);
    outcome_t r;
    r = '0;
    case (op)
      mfb_pkg::OP_BLIT: r.status = blit_span(int'(x), int'(w), int'(y), pattern, mode, solid);
      mfb_pkg::OP_FILL: r.status = fill_rect(int'(x), int'(y), int'(w), int'(h), on);
      mfb_pkg::OP_CLEAR: begin
        foreach (frame[i]) frame[i] = 8'hFF;
        foreach (dirty_rows[i]) dirty_rows[i] = 1'b0;
      end
      mfb_pkg::OP_READ: begin
        if (y >= mfb_pkg::SCREEN_H || bcol >= mfb_pkg::ROW_BYTES) begin
          r.status = mfb_pkg::STAT_OUTSIDE;
        end else begin
          r.data  = frame[int'(y) * mfb_pkg::ROW_BYTES + int'(bcol)];
          r.dirty = dirty_rows[y];
        end
      end
      mfb_pkg::OP_CLEAN: begin
        if (y >= mfb_pkg::SCREEN_H) r.status = mfb_pkg::STAT_OUTSIDE;
        else dirty_rows[y] = 1'b0;
      end
      default: r.status = mfb_pkg::STAT_MODE;
    endcase
    return r;
  endfunction

  // results first: a result can never belong to a command taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with no command outstanding: %s %0d %s %0d %s %0d",
                                    "status", status_i, "data", read_data_i,
                                    "dirty", row_dirty_i));
        end else begin
          head = expected_outcomes.pop_front();
          awaiting--;
          compared++;
          if (status_i !== head.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      compared, status_i, head.status));
          if (read_data_i !== head.data)
            report_mismatch($sformatf("result %0d: read_data 0x%02h, expected 0x%02h",
                                      compared, read_data_i, head.data));
          if (row_dirty_i !== head.dirty)
            report_mismatch($sformatf("result %0d: row_dirty %0d, expected %0d",
                                      compared, row_dirty_i, head.dirty));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_outcomes.push_back(apply_command(op_i, x_pos_i, y_pos_i, width_px_i,
                                                  height_px_i, pattern_i, blit_mode_i,
                                                  fill_solid_i, fill_on_i, byte_col_i));
        awaiting++;
      end
    end
  end

endmodule

FILE: tb/tb_mono_framebuffer_blit_engine_core.sv
// tb_mono_framebuffer_blit_engine_core: command stimulus, result sink and verdict
// for the frame blit engine; depends on mfb_pkg, mono_framebuffer_blit_engine_core
// and mfb_frame_checker
module tb_mono_framebuffer_blit_engine_core;

  localparam int     CLK_PERIOD     = 12;
  localparam int     RESET_CYCLES   = 6;
  localparam int     MAX_GAP        = 18;
  localparam int     RANDOM_ITEMS   = 1250;
  localparam int     BACKLOG_CYCLES = 400;
  localparam int     DRAIN_CYCLES   = 64;
  localparam longint TIMEOUT_CYCLES = 4_000_000;

  typedef struct {
    logic [2:0]  op;
    logic [9:0]  x;
    logic [7:0]  y;
    logic [9:0]  w;
    logic [7:0]  h;
    logic [23:0] pattern;
    logic [1:0]  mode;
    logic        solid;
    logic        on;
    logic [5:0]  bcol;
  } command_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [2:0]  op_i = '0;
  logic [9:0]  x_pos_i = '0;
  logic [7:0]  y_pos_i = '0;
  logic [9:0]  width_px_i = '0;
  logic [7:0]  height_px_i = '0;
  logic [23:0] pattern_i = '0;
  logic [1:0]  blit_mode_i = '0;
  logic        fill_solid_i = 1'b0;
  logic        fill_on_i = 1'b0;
  logic [5:0]  byte_col_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  read_data_o;
  logic        row_dirty_o;

  int mismatches;
  int awaiting;
  int compared;
  bit no_gaps = 1'b0;
  bit want_backlog = 1'b0;
  int hot_row = 0;
  int hot_byte = 0;
  int op_count [8];
  int sent_total = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mono_framebuffer_blit_engine_core dut (.*);

  mfb_frame_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .op_i         (op_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .width_px_i   (width_px_i),
    .height_px_i  (height_px_i),
    .pattern_i    (pattern_i),
    .blit_mode_i  (blit_mode_i),
    .fill_solid_i (fill_solid_i),
    .fill_on_i    (fill_on_i),
    .byte_col_i   (byte_col_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .read_data_i  (read_data_o),
    .row_dirty_i  (row_dirty_o),
    .mismatches_o (mismatches),
    .awaiting_o   (awaiting),
    .compared_o   (compared)
  );

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic command_t make_command(input logic [2:0] op, input int x, input int y,
                                            input int w, input int h, input int pattern,
                                            input logic [1:0] mode, input bit solid,
                                            input bit on, input int bcol);
    command_t c;
    c.op      = op;
    c.x       = 10'(x);
    c.y       = 8'(y);
    c.w       = 10'(w);
    c.h       = 8'(h);
    c.pattern = 24'(pattern);
    c.mode    = mode;
    c.solid   = solid;
    c.on      = on;
    c.bcol    = 6'(bcol);
    return c;
  endfunction

  // mostly well-formed commands, reads aimed at the last blit, some noise
  function automatic command_t random_command();
    command_t c;
    int       kind;
    int       w;
    int       x;
    int       h;
    c = make_command(mfb_pkg::OP_BLIT, $urandom_range(0, 1023), $urandom_range(0, 255),
                     $urandom_range(0, 1023), $urandom_range(0, 255), $urandom,
                     2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                     $urandom_range(0, 63));
    kind = $urandom_range(0, 999);
    if (kind < 450) begin
      w = $urandom_range(1, mfb_pkg::MAX_BLIT);
      x = $urandom_range(0, mfb_pkg::SCREEN_W - w);
      c.w = 10'(w);
      c.x = 10'(x);
      c.y = 8'($urandom_range(0, mfb_pkg::SCREEN_H - 1));
      c.mode = 2'($urandom_range(mfb_pkg::MODE_OR, mfb_pkg::MODE_ANDNOT));
      c.solid = ($urandom_range(0, 5) == 0);
      hot_row = c.y;
      hot_byte = (mfb_pkg::SCREEN_W - w - x) >> 3;
    end else if (kind < 650) begin
      c.op = mfb_pkg::OP_READ;
      if ($urandom_range(0, 1) == 1) begin
        c.y = 8'(hot_row);
        c.bcol = 6'(hot_byte + $urandom_range(0, 3));
      end else begin
        c.y = 8'($urandom_range(0, mfb_pkg::SCREEN_H - 1));
        c.bcol = 6'($urandom_range(0, mfb_pkg::ROW_BYTES - 1));
      end
    end else if (kind < 700) begin
      c.op = mfb_pkg::OP_CLEAN;
      c.y = ($urandom_range(0, 1) == 1) ? 8'(hot_row)
                                         : 8'($urandom_range(0, mfb_pkg::SCREEN_H - 1));
    end else if (kind < 800) begin
      w = $urandom_range(0, 2 * mfb_pkg::MAX_BLIT);
      h = $urandom_range(0, 8);
      c.op = mfb_pkg::OP_FILL;
      c.w = 10'(w);
      c.h = 8'(h);
      c.x = 10'($urandom_range(0, mfb_pkg::SCREEN_W - w));
      c.y = 8'($urandom_range(0, mfb_pkg::SCREEN_H - h));
    end else if (kind < 880) begin
      c.op = mfb_pkg::OP_BLIT;
    end else if (kind < 930) begin
      c.op = mfb_pkg::OP_FILL;
    end else if (kind < 970) begin
      c.op = ($urandom_range(0, 1) == 1) ? mfb_pkg::OP_READ : mfb_pkg::OP_CLEAN;
    end else if (kind < 992) begin
      c.op = mfb_pkg::OP_CLEAN + 3'($urandom_range(1, 3));
    end else if (kind < 997) begin
      c.op = mfb_pkg::OP_CLEAR;
    end else begin
      // rare big rectangle, at least 200 pixels wide and 100 rows high
      w = $urandom_range(200, mfb_pkg::SCREEN_W);
      h = $urandom_range(100, mfb_pkg::SCREEN_H);
      c.op = mfb_pkg::OP_FILL;
      c.w = 10'(w);
      c.h = 8'(h);
      c.x = 10'($urandom_range(0, mfb_pkg::SCREEN_W - w));
      c.y = 8'($urandom_range(0, mfb_pkg::SCREEN_H - h));
    end
    return c;
  endfunction

  task automatic issue(input command_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= c.op;
    x_pos_i      <= c.x;
    y_pos_i      <= c.y;
    width_px_i   <= c.w;
    height_px_i  <= c.h;
    pattern_i    <= c.pattern;
    blit_mode_i  <= c.mode;
    fill_solid_i <= c.solid;
    fill_on_i    <= c.on;
    byte_col_i   <= c.bcol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    op_count[c.op]++;
    sent_total++;
  endtask

  initial begin : result_sink
    int hold;
    forever begin
      hold = draw_gap();
      if (want_backlog) begin
        hold = BACKLOG_CYCLES;
        want_backlog = 1'b0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fresh frame, then blits at both screen edges and the solid variants
    issue(make_command(mfb_pkg::OP_READ, 0, 0, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, 0, 0, mfb_pkg::MAX_BLIT, 0, 'hFF_FFFF,
                       mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, mfb_pkg::SCREEN_W - mfb_pkg::MAX_BLIT,
                       mfb_pkg::SCREEN_H - 1, mfb_pkg::MAX_BLIT, 0,
                       'hAA_AAAA, mfb_pkg::MODE_XOR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, mfb_pkg::SCREEN_W - 1, 1, 1, 0, 0,
                       mfb_pkg::MODE_ANDNOT, 1'b1, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, 3, 7, 13, 0, 'h55_5555, mfb_pkg::MODE_OR,
                       1'b1, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, 100, 7, 17, 0, 'h12_3456, mfb_pkg::MODE_XOR,
                       1'b1, 1'b0, 0));
    // error precedence: width before screen before mode, then reads and cleans at and beyond the screen edges
    issue(make_command(mfb_pkg::OP_BLIT, 10, 10, 0, 0, 'hFF_FFFF, mfb_pkg::MODE_OR,
                       1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, 1023, 255, 1023, 255, 'hFF_FFFF,
                       mfb_pkg::MODE_BAD, 1'b1, 1'b1, 63));
    issue(make_command(mfb_pkg::OP_BLIT, mfb_pkg::SCREEN_W, 0, 1, 0, 1, mfb_pkg::MODE_OR,
                       1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, mfb_pkg::SCREEN_W - 10, 0, 11, 0, 1,
                       mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, 0, 255, 8, 0, 1, mfb_pkg::MODE_BAD,
                       1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_BLIT, 5, 5, 8, 0, 1, mfb_pkg::MODE_BAD, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_READ, 0, 0, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0,
                       mfb_pkg::ROW_BYTES - 1));
    issue(make_command(mfb_pkg::OP_READ, 0, mfb_pkg::SCREEN_H - 1, 0, 0, 0,
                       mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_READ, 0, 255, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 63));
    issue(make_command(mfb_pkg::OP_CLEAN, 0, 0, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_CLEAN, 0, 255, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    // rectangles: empty, multi-strip with a narrow last strip, off screen
    issue(make_command(mfb_pkg::OP_FILL, 0, 0, 0, 5, 0, mfb_pkg::MODE_OR, 1'b0, 1'b1, 0));
    issue(make_command(mfb_pkg::OP_FILL, 1, 2, 50, 3, 0, mfb_pkg::MODE_OR, 1'b0, 1'b1, 0));
    issue(make_command(mfb_pkg::OP_FILL, 10, 3, 30, 1, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_FILL, 1023, 255, 1023, 255, 'hFF_FFFF,
                       mfb_pkg::MODE_BAD, 1'b1, 1'b1, 63));
    issue(make_command(mfb_pkg::OP_FILL, 0, mfb_pkg::SCREEN_H - 10, 8, 20, 0,
                       mfb_pkg::MODE_OR, 1'b0, 1'b1, 0));
    issue(make_command(mfb_pkg::OP_CLEAN + 3'd3, 1023, 255, 1023, 255, 'hFF_FFFF,
                       mfb_pkg::MODE_BAD, 1'b1, 1'b1, 63));
    issue(make_command(mfb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_READ, 0, 0, 0, 0, 0, mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_FILL, 0, 0, mfb_pkg::SCREEN_W, mfb_pkg::SCREEN_H, 0,
                       mfb_pkg::MODE_OR, 1'b0, 1'b0, 0));
    issue(make_command(mfb_pkg::OP_READ, 0, mfb_pkg::SCREEN_H / 2, 0, 0, 0,
                       mfb_pkg::MODE_OR, 1'b0, 1'b0, mfb_pkg::ROW_BYTES / 2));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch of back-to-back transactions on both sides every 300 commands
      no_gaps = (n % 300) >= 240;
      if (n == 400) want_backlog = 1'b1;
      issue(random_command());
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (awaiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands: %0d blits, %0d fills, %0d clears, %0d reads, %0d cleans",
             sent_total, op_count[mfb_pkg::OP_BLIT], op_count[mfb_pkg::OP_FILL],
             op_count[mfb_pkg::OP_CLEAR], op_count[mfb_pkg::OP_READ],
             op_count[mfb_pkg::OP_CLEAN]);
    $display("%0d undefined opcodes, %0d results compared, %0d mismatches",
             sent_total - op_count[mfb_pkg::OP_BLIT] - op_count[mfb_pkg::OP_FILL]
             - op_count[mfb_pkg::OP_CLEAR] - op_count[mfb_pkg::OP_READ]
             - op_count[mfb_pkg::OP_CLEAN], compared, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
